### design/lebuf_pkg.sv
// lebuf_pkg: shared widths, command codes and the result record of the line edit buffer
// used by lebuf_ctrl and line_edit_buffer; depends on nothing else
package lebuf_pkg;

  localparam int unsigned LINE_COLUMNS_DEF = 80;

  localparam int unsigned CMD_W  = 4;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned LEN_W  = 7;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 4'd0,
    CMD_BACKSPACE = 4'd1,
    CMD_DELETE    = 4'd2,
    CMD_LEFT      = 4'd3,
    CMD_RIGHT     = 4'd4,
    CMD_HOME      = 4'd5,
    CMD_END       = 4'd6,
    CMD_CLEAR     = 4'd7,
    CMD_READ      = 4'd8
  } cmd_e;

  typedef struct packed {
    logic              changed;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  cursor_pos;
    logic [LEN_W-1:0]  line_length;
  } res_t;

endpackage

### design/lebuf_ram.sv
// lebuf_ram: generic single-clock ram, one write port and one registered read port
// no package dependency
module lebuf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 81
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/lebuf_ctrl.sv
// lebuf_ctrl: command decoder and shift sequencer over the line store ram
// depends on lebuf_pkg; drives one lebuf_ram instance in the top level
module lebuf_ctrl
  import lebuf_pkg::*;
#(
  parameter int unsigned LINE_COLUMNS = LINE_COLUMNS_DEF,
  parameter int unsigned AW           = $clog2(LINE_COLUMNS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic [IDX_W-1:0]  idx_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [CHAR_W-1:0] ram_wdata_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [CHAR_W-1:0] ram_rdata_i
);

  localparam int unsigned CW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW-1:0] LEN_MAX = AW'(LINE_COLUMNS - 1);
  localparam logic [AW-1:0] ONE = AW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     len_q, len_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     src_q, src_d;
  logic [AW-1:0]     stop_q, stop_d;
  logic [AW-1:0]     dst_q, dst_d;
  logic              ins_q, ins_d;
  logic              pend_q, pend_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic [CHAR_W-1:0] chr_q, chr_d;
  logic              chg_q, chg_d;
  cmd_e              cmd;

  assign cmd = cmd_e'(cmd_i);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cur_d       = cur_q;
    src_d       = src_q;
    stop_d      = stop_q;
    dst_d       = dst_q;
    ins_d       = ins_q;
    pend_d      = pend_q;
    ch_d        = ch_q;
    chr_d       = chr_q;
    chg_d       = chg_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = dst_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = src_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        ram_raddr_o = AW'(idx_i);
        if (req_valid_i) begin
          chr_d   = '0;
          chg_d   = 1'b0;
          pend_d  = 1'b0;
          state_d = S_DONE;
          unique case (cmd)
            CMD_INSERT: begin
              if (len_q < LEN_MAX) begin
                chg_d  = 1'b1;
                len_d  = len_q + ONE;
                cur_d  = cur_q + ONE;
                ch_d   = char_i;
                stop_d = cur_q;
                ins_d  = 1'b1;
                if (cur_q == len_q) begin
                  ram_we_o    = 1'b1;
                  ram_waddr_o = cur_q;
                  ram_wdata_o = char_i;
                end else begin
                  src_d   = len_q - ONE;
                  state_d = S_SHIFT;
                end
              end
            end
            CMD_BACKSPACE: begin
              if (cur_q != '0 && len_q != '0) begin
                chg_d = 1'b1;
                cur_d = cur_q - ONE;
                len_d = len_q - ONE;
                ins_d = 1'b0;
                if (cur_q < len_q) begin
                  src_d   = cur_q;
                  stop_d  = len_q - ONE;
                  state_d = S_SHIFT;
                end
              end
            end
            CMD_DELETE: begin
              if (len_q != '0 && cur_q < len_q) begin
                chg_d = 1'b1;
                len_d = len_q - ONE;
                ins_d = 1'b0;
                if (cur_q + ONE < len_q) begin
                  src_d   = cur_q + ONE;
                  stop_d  = len_q - ONE;
                  state_d = S_SHIFT;
                end
              end
            end
            CMD_LEFT: begin
              if (cur_q != '0) begin
                cur_d = cur_q - ONE;
                chg_d = 1'b1;
              end
            end
            CMD_RIGHT: begin
              if (cur_q < len_q) begin
                cur_d = cur_q + ONE;
                chg_d = 1'b1;
              end
            end
            CMD_HOME: begin
              if (cur_q != '0) begin
                cur_d = '0;
                chg_d = 1'b1;
              end
            end
            CMD_END: begin
              if (cur_q != len_q) begin
                cur_d = len_q;
                chg_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              chg_d = (len_q != '0) || (cur_q != '0);
              len_d = '0;
              cur_d = '0;
            end
            CMD_READ: begin
              // slots at or above the length read as zero
              if (CW'(idx_i) < CW'(len_q)) begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        chr_d   = ram_rdata_i;
        state_d = S_DONE;
      end
      S_SHIFT: begin
        ram_we_o = pend_q;
        pend_d   = 1'b1;
        dst_d    = ins_q ? src_q + ONE : src_q - ONE;
        if (src_q == stop_q) begin
          state_d = S_DRAIN;
        end else begin
          src_d = ins_q ? src_q - ONE : src_q + ONE;
        end
      end
      S_DRAIN: begin
        ram_we_o = 1'b1;
        pend_d   = 1'b0;
        state_d  = ins_q ? S_PUT : S_DONE;
      end
      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = stop_q;
        ram_wdata_o = ch_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      cur_q   <= '0;
      src_q   <= '0;
      stop_q  <= '0;
      dst_q   <= '0;
      ins_q   <= 1'b0;
      pend_q  <= 1'b0;
      ch_q    <= '0;
      chr_q   <= '0;
      chg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      src_q   <= src_d;
      stop_q  <= stop_d;
      dst_q   <= dst_d;
      ins_q   <= ins_d;
      pend_q  <= pend_d;
      ch_q    <= ch_d;
      chr_q   <= chr_d;
      chg_q   <= chg_d;
    end
  end

  assign res_o.line_length = LEN_W'(len_q);
  assign res_o.cursor_pos  = LEN_W'(cur_q);
  assign res_o.char_out    = chr_q;
  assign res_o.changed     = chg_q;

endmodule

### design/line_edit_buffer.sv
// line_edit_buffer: top level of the editable text line with length and cursor
// depends on lebuf_pkg, lebuf_ram and lebuf_ctrl
//
//   channel  dir  tdata fields (low bit up)                          request
//   s_axis   in   command[3:0] char_in[11:4] read_index[18:12]       one command
//   m_axis   out  line_length[6:0] cursor_pos[13:7] char_out[21:14]  one result
//                 changed[22]
//
// one command at a time; an insert with a tail passes the shift, drain and put states, a
// backspace or delete with a tail the shift and drain states, a read below the length the
// read state; every command then waits in the done state until the output register takes it
// the tail shift moves one byte per cycle through the store ram's single write port
// reset clears length and cursor; slots at or above the length always read as zero
// the output register takes a result while m_axis stalls, and s_axis waits after that
module line_edit_buffer
  import lebuf_pkg::*;
#(
  parameter int unsigned LINE_COLUMNS = LINE_COLUMNS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // command, char_in, read_index, zero pad
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // line_length, cursor_pos, char_out,
                                                 // changed, zero pad
);

  localparam int unsigned STORE_DEPTH = LINE_COLUMNS + 1;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_q;
  res_t              out_q;

  lebuf_ctrl #(
    .LINE_COLUMNS(LINE_COLUMNS),
    .AW          (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .cmd_i      (s_axis_tdata_i[CMD_W-1:0]),
    .char_i     (s_axis_tdata_i[CMD_W+CHAR_W-1:CMD_W]),
    .idx_i      (s_axis_tdata_i[CMD_W+CHAR_W+IDX_W-1:CMD_W+CHAR_W]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  lebuf_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_q);

endmodule
